[hw/rtl/ehrb_pkg.sv]
package ehrb_pkg;

   localparam logic       FUNC_RECORD = 1'b0;
   localparam logic       FUNC_READ   = 1'b1;

   localparam logic [1:0] KIND_PRES_START = 2'd0;
   localparam logic [1:0] KIND_PRES_END   = 2'd1;
   localparam logic [1:0] KIND_LIGHT_ON   = 2'd2;
   localparam logic [1:0] KIND_LIGHT_OFF  = 2'd3;

   // first second of 2024 in unix time
   localparam logic [62:0] WALL_2024 = 63'd1704067200;

   typedef struct packed {
      logic        func;
      logic [1:0]  event_kind;
      logic [15:0] target_range;
      logic [15:0] dwell_time;
      logic [7:0]  light_source;
      logic [31:0] uptime_now;
      logic [62:0] wall_now;
      logic [6:0]  read_max;
      logic [15:0] read_skip;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic        last_of_run;
      logic [1:0]  entry_kind;
      logic [15:0] entry_distance;
      logic [15:0] entry_duration;
      logic [7:0]  entry_source;
      logic [31:0] entry_uptime;
      logic [62:0] entry_wall;
      logic [8:0]  held_count;
      logic [31:0] presence_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] distance;
      logic [15:0] duration;
      logic [7:0]  source;
      logic [31:0] uptime;
      logic [62:0] wall;
   } entry_type;

endpackage

[hw/rtl/ehrb_store.sv]
module ehrb_store #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  ehrb_pkg::req_type        wr_req,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output ehrb_pkg::entry_type      rd_data
);

   ehrb_pkg::entry_type mem [DEPTH];
   ehrb_pkg::entry_type wr_entry;
   ehrb_pkg::entry_type rd_data_ff;

   always_comb begin
      wr_entry          = '0;
      wr_entry.kind     = wr_req.event_kind;
      wr_entry.uptime   = wr_req.uptime_now;
      case (wr_req.event_kind) inside
         ehrb_pkg::KIND_PRES_START, ehrb_pkg::KIND_PRES_END: begin
            wr_entry.distance = wr_req.target_range;
            wr_entry.duration = wr_req.dwell_time;
         end
         default: begin
            wr_entry.source = wr_req.light_source;
         end
      endcase
      // clock not yet set
      if (wr_req.wall_now >= ehrb_pkg::WALL_2024) begin
         wr_entry.wall = wr_req.wall_now;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/event_history_ring_buffer_core.sv]
// Circular event history of LOG_DEPTH entries.
// req channel: one beat is either a record (func 0) or a read (func 1).
// A record writes one entry over the oldest when full and answers with one
// rsp beat (entry_valid 0, last_of_run 1) carrying the updated counts.
// A read returns up to read_max entries (capped at READ_BURST) newest first,
// after skipping read_skip entries; the final beat has last_of_run set.
// A read that finds nothing returns a single beat with entry_valid 0.
// A record or empty read answers in the cycle after acceptance; a read with
// entries passes each entry through the store's read register and then the
// rsp register, giving one beat per cycle while rsp_ready is high.
// req_ready is high only while no read is streaming and the rsp register is
// free or being taken, so a new beat follows the last rsp beat of the
// previous one with no gap.
// When rsp_ready is low the current rsp beat holds and streaming pauses.
// Reset empties the history and clears the presence counter; the memory
// itself is not cleared, entries beyond the held count are never read.
module event_history_ring_buffer_core #(
   parameter int LOG_DEPTH  = 256,
   parameter int READ_BURST = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ehrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ehrb_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(LOG_DEPTH);
   localparam int HW = $clog2(LOG_DEPTH + 1);
   localparam int CW = (HW > 16) ? HW : 16;
   localparam int MW = (HW > 7) ? HW : 7;
   localparam int RW = $clog2(READ_BURST + 1);
   localparam int SW = HW + 1;

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   state_type           state_ff;
   logic [AW-1:0]       slot_ff;
   logic [HW-1:0]       held_ff;
   logic [31:0]         presence_ff;
   logic [AW-1:0]       ptr_ff;
   logic [RW-1:0]       remain_ff;
   logic                rsp_valid_ff;
   ehrb_pkg::rsp_type   rsp_ff;

   logic                rsp_valid_in;
   ehrb_pkg::rsp_type   rsp_in;
   logic                out_free;
   logic                req_fire;
   logic                is_record;
   logic [6:0]          rmax_sat;
   logic                skip_lt;
   logic [HW-1:0]       avail;
   logic [RW-1:0]       n_count;
   logic [HW-1:0]       skip1;
   logic [SW-1:0]       start_sum;
   logic [AW-1:0]       start_ptr;
   logic [AW-1:0]       ptr_dec;
   logic [AW-1:0]       slot_inc;
   logic [HW-1:0]       held_inc;
   logic [31:0]         presence_inc;
   logic                wr_en;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   ehrb_pkg::entry_type rd_entry;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_record = (req_data.func == ehrb_pkg::FUNC_RECORD);

   always_comb begin
      rmax_sat = (req_data.read_max > 7'(READ_BURST)) ? 7'(READ_BURST) : req_data.read_max;
      skip_lt  = CW'(req_data.read_skip) < CW'(held_ff);
      avail    = skip_lt ? (held_ff - HW'(req_data.read_skip)) : '0;
      n_count  = (MW'(avail) < MW'(rmax_sat)) ? RW'(avail) : RW'(rmax_sat);
      // newest entry to return sits skip + 1 behind the write slot
      skip1    = HW'(req_data.read_skip) + HW'(1);
      if (SW'(slot_ff) >= SW'(skip1)) begin
         start_sum = SW'(slot_ff) - SW'(skip1);
      end else begin
         start_sum = SW'(slot_ff) + SW'(LOG_DEPTH) - SW'(skip1);
      end
      start_ptr = start_sum[AW-1:0];
      ptr_dec   = (ptr_ff == '0) ? AW'(LOG_DEPTH - 1) : ptr_ff - AW'(1);
      slot_inc  = (slot_ff == AW'(LOG_DEPTH - 1)) ? '0 : slot_ff + AW'(1);
      held_inc  = (held_ff == HW'(LOG_DEPTH)) ? held_ff : held_ff + HW'(1);
      presence_inc = (req_data.event_kind == ehrb_pkg::KIND_PRES_START) ?
                     presence_ff + 32'd1 : presence_ff;
   end

   assign wr_en = req_fire && is_record;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_dec;
      if (state_ff == ST_IDLE) begin
         rd_addr = start_ptr;
         rd_en   = req_fire && !is_record && (n_count != '0);
      end else begin
         rd_en   = out_free && (remain_ff != RW'(1));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (state_ff == ST_IDLE) begin
         if (req_fire && (is_record || (n_count == '0))) begin
            rsp_valid_in          = 1'b1;
            rsp_in                = '0;
            rsp_in.last_of_run    = 1'b1;
            rsp_in.held_count     = is_record ? 9'(held_inc) : 9'(held_ff);
            rsp_in.presence_total = is_record ? presence_inc : presence_ff;
         end
      end else if (out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.entry_valid    = 1'b1;
         rsp_in.last_of_run    = (remain_ff == RW'(1));
         rsp_in.entry_kind     = rd_entry.kind;
         rsp_in.entry_distance = rd_entry.distance;
         rsp_in.entry_duration = rd_entry.duration;
         rsp_in.entry_source   = rd_entry.source;
         rsp_in.entry_uptime   = rd_entry.uptime;
         rsp_in.entry_wall     = rd_entry.wall;
         rsp_in.held_count     = 9'(held_ff);
         rsp_in.presence_total = presence_ff;
      end
   end

   ehrb_store #(
      .DEPTH(LOG_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_req  (req_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         held_ff      <= '0;
         presence_ff  <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (is_record) begin
                     slot_ff     <= slot_inc;
                     held_ff     <= held_inc;
                     presence_ff <= presence_inc;
                  end else if (n_count != '0) begin
                     ptr_ff    <= start_ptr;
                     remain_ff <= n_count;
                     state_ff  <= ST_STREAM;
                  end
               end
            end
            ST_STREAM: begin
               if (out_free) begin
                  remain_ff <= remain_ff - RW'(1);
                  ptr_ff    <= ptr_dec;
                  if (remain_ff == RW'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= HW'(LOG_DEPTH)) && (slot_ff <= AW'(LOG_DEPTH - 1)))
      else $error("held count or write slot out of range");

   a_stream_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> (remain_ff != '0))
      else $error("streaming with nothing left");

   a_not_last_streams: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_of_run) |-> (state_ff == ST_STREAM))
      else $error("non-final beat outside a read");

   a_no_write_in_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STREAM) |-> !wr_en)
      else $error("history written during a read");

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH     = 256;
   localparam int BURST_MAX      = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ehrb_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ehrb_pkg::rsp_type rsp_data;

   event_history_ring_buffer_core #(
      .LOG_DEPTH  (HIST_DEPTH),
      .READ_BURST (BURST_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted history state
   ehrb_pkg::entry_type history [HIST_DEPTH];
   logic [7:0]          next_slot   = '0;
   logic [8:0]          held_n      = '0;
   logic [31:0]         starts_seen = '0;
   ehrb_pkg::rsp_type   expected_beats [$];

   int send_idle_pct = 9;
   int recv_idle_pct = 76;
   int errors = 0;
   int records_sent = 0;
   int reads_sent = 0;
   int slot_wraps = 0;
   int beats_checked = 0;
   int entries_checked = 0;
   int idle_cycles = 0;

   function automatic ehrb_pkg::rsp_type status_beat(input logic valid, input logic last);
      ehrb_pkg::rsp_type b;
      b = '0;
      b.entry_valid    = valid;
      b.last_of_run    = last;
      b.held_count     = held_n;
      b.presence_total = starts_seen;
      return b;
   endfunction

   task automatic predict_history(input ehrb_pkg::req_type item);
      ehrb_pkg::entry_type e;
      ehrb_pkg::rsp_type   b;
      int                  limit;
      int                  avail;
      int                  n;
      logic [7:0]          idx;
      if (item.func == ehrb_pkg::FUNC_RECORD) begin
         e = '0;
         e.kind = item.event_kind;
         if (item.event_kind == ehrb_pkg::KIND_PRES_START ||
             item.event_kind == ehrb_pkg::KIND_PRES_END) begin
            e.distance = item.target_range;
            e.duration = item.dwell_time;
         end else begin
            e.source = item.light_source;
         end
         e.uptime = item.uptime_now;
         e.wall   = (item.wall_now >= ehrb_pkg::WALL_2024) ? item.wall_now : '0;
         if (item.event_kind == ehrb_pkg::KIND_PRES_START)
            starts_seen = starts_seen + 32'd1;
         history[next_slot] = e;
         next_slot = next_slot + 8'd1;
         if (next_slot == 8'd0)
            slot_wraps++;
         if (held_n < HIST_DEPTH)
            held_n = held_n + 9'd1;
         expected_beats.push_back(status_beat(1'b0, 1'b1));
         records_sent++;
      end else begin
         reads_sent++;
         limit = (item.read_max > BURST_MAX) ? BURST_MAX : int'(item.read_max);
         avail = (item.read_skip < held_n) ? int'(held_n) - int'(item.read_skip) : 0;
         n = (avail < limit) ? avail : limit;
         if (n == 0) begin
            expected_beats.push_back(status_beat(1'b0, 1'b1));
         end else begin
            for (int i = 0; i < n; i++) begin
               idx = next_slot - 8'(int'(item.read_skip) + i + 1);
               e = history[idx];
               b = status_beat(1'b1, i == n - 1);
               b.entry_kind     = e.kind;
               b.entry_distance = e.distance;
               b.entry_duration = e.duration;
               b.entry_source   = e.source;
               b.entry_uptime   = e.uptime;
               b.entry_wall     = e.wall;
               expected_beats.push_back(b);
            end
         end
      end
   endtask

   task automatic send_item(input ehrb_pkg::req_type item);
      int gaps;
      gaps = 0;
      @(negedge clock);
      while (gaps < 50 && $urandom_range(99) < send_idle_pct)
         gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      predict_history(item);
   endtask

   function automatic ehrb_pkg::req_type record_item(input logic [1:0] kind,
                                                     input logic [15:0] span,
                                                     input logic [15:0] dur,
                                                     input logic [7:0] src,
                                                     input logic [31:0] up,
                                                     input logic [62:0] wall);
      ehrb_pkg::req_type r;
      r.func         = ehrb_pkg::FUNC_RECORD;
      r.event_kind   = kind;
      r.target_range = span;
      r.dwell_time   = dur;
      r.light_source = src;
      r.uptime_now   = up;
      r.wall_now     = wall;
      r.read_max     = 7'($urandom);
      r.read_skip    = 16'($urandom);
      return r;
   endfunction

   function automatic ehrb_pkg::req_type read_item(input logic [6:0] rmax,
                                                   input logic [15:0] skip);
      ehrb_pkg::req_type r;
      r.func         = ehrb_pkg::FUNC_READ;
      r.event_kind   = 2'($urandom);
      r.target_range = 16'($urandom);
      r.dwell_time   = 16'($urandom);
      r.light_source = 8'($urandom);
      r.uptime_now   = $urandom;
      r.wall_now     = 63'({$urandom, $urandom});
      r.read_max     = rmax;
      r.read_skip    = skip;
      return r;
   endfunction

   function automatic ehrb_pkg::req_type random_item();
      ehrb_pkg::req_type r;
      logic [62:0]       wall;
      logic [6:0]        rmax;
      logic [15:0]       skip;
      case ($urandom_range(3))
         0: wall = ehrb_pkg::WALL_2024 - 63'd4 + 63'($urandom_range(8));
         1: wall = 63'($urandom);
         default: wall = 63'({$urandom, $urandom});
      endcase
      rmax = ($urandom_range(3) != 0) ? 7'($urandom_range(70)) : 7'($urandom_range(127));
      skip = ($urandom_range(3) != 0) ? 16'($urandom_range(int'(held_n) + 4))
                                      : 16'($urandom_range(65535));
      if ($urandom_range(99) < 80)
         r = record_item(2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                         $urandom, wall);
      else
         r = read_item(rmax, skip);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endfunction

   ehrb_pkg::rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected rsp beat, expected none, actual %0h", $time, rsp_data);
         end else begin
            want = expected_beats.pop_front();
            if (want.entry_valid)
               entries_checked++;
            check_field("entry_valid", want.entry_valid, rsp_data.entry_valid);
            check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            check_field("entry_kind", want.entry_kind, rsp_data.entry_kind);
            check_field("entry_distance", want.entry_distance, rsp_data.entry_distance);
            check_field("entry_duration", want.entry_duration, rsp_data.entry_duration);
            check_field("entry_source", want.entry_source, rsp_data.entry_source);
            check_field("entry_uptime", want.entry_uptime, rsp_data.entry_uptime);
            check_field("entry_wall", want.entry_wall, rsp_data.entry_wall);
            check_field("held_count", want.held_count, rsp_data.held_count);
            check_field("presence_total", want.presence_total, rsp_data.presence_total);
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_read();
      send_item(read_item(7'd64, 16'd0));
      send_item(read_item(7'd0, 16'd0));
   endtask

   task automatic test_record_kinds();
      send_item(record_item(ehrb_pkg::KIND_PRES_START, 16'hffff, 16'hffff, 8'hff,
                            32'hffff_ffff, 63'h7fff_ffff_ffff_ffff));
      send_item(record_item(ehrb_pkg::KIND_PRES_END, 16'h0000, 16'h0000, 8'h00, 32'h0,
                            63'd0));
      send_item(record_item(ehrb_pkg::KIND_LIGHT_ON, 16'hffff, 16'hffff, 8'hff,
                            32'h1234_5678, ehrb_pkg::WALL_2024 - 63'd1));
      send_item(record_item(ehrb_pkg::KIND_LIGHT_OFF, 16'h0000, 16'h0000, 8'h5a,
                            32'h0000_0001, ehrb_pkg::WALL_2024));
      send_item(read_item(7'd4, 16'd0));
   endtask

   task automatic test_read_limits();
      send_item(read_item(7'd127, 16'd0));
      send_item(read_item(7'd1, 16'd0));
      send_item(read_item(7'd2, 16'd3));
      send_item(read_item(7'd64, 16'd4));
      send_item(read_item(7'd64, 16'hffff));
      send_item(read_item(7'd64, 16'd1));
      send_item(read_item(7'd0, 16'd0));
   endtask

   task automatic test_wall_threshold();
      send_item(record_item(ehrb_pkg::KIND_PRES_START, 16'd150, 16'd30, 8'h00, 32'd100,
                            ehrb_pkg::WALL_2024 - 63'd1));
      send_item(record_item(ehrb_pkg::KIND_LIGHT_ON, 16'd0, 16'd0, 8'd3, 32'd101,
                            ehrb_pkg::WALL_2024));
      send_item(record_item(ehrb_pkg::KIND_PRES_END, 16'd75, 16'd600, 8'h11, 32'd102,
                            ehrb_pkg::WALL_2024 + 63'd1));
      send_item(record_item(ehrb_pkg::KIND_LIGHT_OFF, 16'd9, 16'd9, 8'd7, 32'd103, 63'd1));
      send_item(record_item(ehrb_pkg::KIND_PRES_START, 16'd1, 16'd1, 8'd0, 32'd104,
                            63'h4000_0000_0000_0000));
      send_item(read_item(7'd8, 16'd0));
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count)
         send_item(random_item());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_read();
      test_record_kinds();
      test_read_limits();
      test_wall_threshold();
      test_random_traffic(104, 9, 76);
      test_random_traffic(104, 76, 9);
      test_random_traffic(104, 0, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d records and %0d reads, checked %0d rsp beats (%0d history entries)",
               records_sent, reads_sent, beats_checked, entries_checked);
      $display("history ended holding %0d entries after the write slot wrapped %0d times",
               held_n, slot_wraps);
      if (errors == 0 && expected_beats.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
